FILE: rtl/core/sme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg: shared definitions for the stack machine execute unit
// Opcodes, error codes, emit kinds, controller states and the command and
// status structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int SADDR_W     = $clog2(STACK_DEPTH);
  localparam int DIV_STEPS   = 32;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    OP_HLT = 4'd0, OP_PSH = 4'd1, OP_POP = 4'd2, OP_ADD = 4'd3,
    OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_SET = 4'd7,
    OP_MOV = 4'd8, OP_IF = 4'd9, OP_IFN = 4'd10, OP_GLD = 4'd11,
    OP_GPT = 4'd12, OP_LOG = 4'd13, OP_NOP = 4'd14, OP_NP2 = 4'd15
  } op_t;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_UNDER  = 3'd1;
  localparam logic [2:0] ERR_OVER   = 3'd2;
  localparam logic [2:0] ERR_BADREG = 3'd3;
  localparam logic [2:0] ERR_DIVZ   = 3'd4;
  localparam logic [2:0] ERR_DIVOV  = 3'd5;

  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_POP  = 2'd1;
  localparam logic [1:0] EMIT_LOG  = 2'd2;

  localparam logic [3:0] REG_IP = 4'd8;
  localparam logic [3:0] REG_SP = 4'd9;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_EXEC, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;     // zero one stack entry of the clearing pass
    logic load;      // capture the input transaction
    logic rd_top;    // read the word at SP-1
    logic rd_next;   // read the word at SP-2
    logic exec;      // perform the instruction and build the result
    logic div_start; // start the divider
    logic div_step;  // one divider iteration
    logic div_fin;   // finish a division
  } cmd_t;

  typedef struct packed {
    logic is_div;     // loaded instruction needs the divider
    logic div_done;   // divider has finished its iterations
    logic clear_done; // clearing pass is at the last stack entry
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/sme_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sme_ctrl: sequencing controller
// Clears the stack after reset, then steps each instruction through load,
// two stack reads, execution and an optional division, and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
module sme_ctrl import sme_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd_top = 1'b1;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_next = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_fin = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/sme_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sme_dpath: execution datapath
// Register file, stack memory zeroed by a clearing pass after reset, the
// stack pointer checks, the arithmetic and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module sme_dpath import sme_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [3:0]  in_op,
  input  wire logic [31:0] in_imm_first,
  input  wire logic [31:0] in_imm_second,
  input  wire logic [31:0] in_imm_third,
  output logic [31:0]      out_next_ip,
  output logic [1:0]       out_emit_kind,
  output logic [31:0]      out_emit_value,
  output logic             out_halted,
  output logic [2:0]       out_error_code
);

  logic [31:0] gregs_r [8];
  logic [31:0] ip_r, sp_r;
  logic        halt_r;
  logic [31:0] mem [STACK_DEPTH];
  logic [SADDR_W-1:0] clr_addr_r;

  logic [3:0]  op_r;
  logic [31:0] i1_r, i2_r, i3_r;
  logic [31:0] rdata_r, a_r;

  // Divider state: magnitudes, quotient and partial remainder.
  logic [31:0] dq_r, dd_r;
  logic [32:0] drem_r;
  logic        dneg_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [31:0] res_ip_r;
  logic [1:0]  res_kind_r;
  logic [31:0] res_val_r;
  logic        res_halt_r;
  logic [2:0]  res_err_r;

  logic commit;
  assign commit = cmd.exec || cmd.div_fin;

  // The word at SP-2 stays in the read register from the second read onwards.
  logic [31:0] b_v;
  assign b_v = rdata_r;

  // Register the instruction and issue the stack reads.
  logic [SADDR_W-1:0] rd_addr;
  always_comb begin
    rd_addr = cmd.rd_top ? SADDR_W'(sp_r - 32'd1) : SADDR_W'(sp_r - 32'd2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      i1_r <= in_imm_first;
      i2_r <= in_imm_second;
      i3_r <= in_imm_third;
    end
    if (cmd.rd_next) a_r <= rdata_r;
  end

  // Instruction decode and checks.
  logic [31:0] ip_adv;
  logic [1:0]  cnt;
  always_comb begin
    unique case (op_t'(op_r))
      OP_PSH, OP_GLD, OP_GPT, OP_LOG: cnt = 2'd1;
      OP_MOV:                         cnt = 2'd2;
      OP_IF, OP_IFN:                  cnt = 2'd3;
      default:                        cnt = 2'd0;
    endcase
    ip_adv = ip_r + 32'd1 + {30'd0, cnt};
  end

  function automatic logic [2:0] pop_chk(input logic [31:0] sp, input logic [1:0] n);
    if (sp[31] || sp < {30'd0, n}) return ERR_UNDER;
    if (sp > 32'(STACK_DEPTH))     return ERR_OVER;
    return ERR_NONE;
  endfunction

  function automatic logic [2:0] push_chk(input logic [31:0] sp);
    if (sp[31])                     return ERR_UNDER;
    if (sp >= 32'(STACK_DEPTH))     return ERR_OVER;
    return ERR_NONE;
  endfunction

  function automatic logic reg_ok(input logic [31:0] idx);
    return idx <= 32'd9;
  endfunction

  logic [31:0] rd1_val;
  always_comb begin
    if (i1_r == 32'd8)      rd1_val = ip_adv;
    else if (i1_r == 32'd9) rd1_val = sp_r;
    else                    rd1_val = gregs_r[i1_r[2:0]];
  end

  // One 32x32 multiplier, both operands from registers.
  logic [31:0] prod;
  assign prod = a_r * b_v;

  logic [32:0] dtrial;
  logic [31:0] dquot;
  assign dtrial = {drem_r[31:0], dd_r[31]} - {1'b0, dq_r};
  assign dquot  = dneg_r ? (32'd0 - dd_r) : dd_r;

  // Next architectural state and result of the loaded instruction.
  logic [2:0]         ex_err;
  logic [31:0]        ex_ip, ex_sp, ex_val;
  logic [1:0]         ex_kind;
  logic               ex_halt;
  logic               ex_greg_we;
  logic [2:0]         ex_greg_idx;
  logic [31:0]        ex_greg_data;
  logic               ex_mem_we;
  logic [SADDR_W-1:0] ex_mem_addr;
  logic [31:0]        ex_mem_data;

  always_comb begin
    ex_err       = ERR_NONE;
    ex_ip        = ip_adv;
    ex_sp        = sp_r;
    ex_kind      = EMIT_NONE;
    ex_val       = '0;
    ex_halt      = halt_r;
    ex_greg_we   = 1'b0;
    ex_greg_idx  = '0;
    ex_greg_data = '0;
    ex_mem_we    = 1'b0;
    ex_mem_addr  = SADDR_W'(sp_r);
    ex_mem_data  = '0;
    if (halt_r) begin
      ex_ip = ip_r;
    end else begin
      unique case (op_t'(op_r))
        OP_HLT: ex_halt = 1'b1;
        OP_PSH: begin
          ex_err = push_chk(sp_r);
          if (ex_err == ERR_NONE) begin
            ex_mem_we   = 1'b1;
            ex_mem_data = i1_r;
            ex_sp       = sp_r + 32'd1;
          end
        end
        OP_POP: begin
          ex_err = pop_chk(sp_r, 2'd1);
          if (ex_err == ERR_NONE) begin
            ex_sp   = sp_r - 32'd1;
            ex_kind = EMIT_POP;
            ex_val  = a_r;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          ex_err = pop_chk(sp_r, 2'd2);
          if (ex_err == ERR_NONE && op_t'(op_r) == OP_DIV) begin
            if (b_v == 32'd0) ex_err = ERR_DIVZ;
            else if (a_r == 32'h8000_0000 && b_v == 32'hFFFF_FFFF) ex_err = ERR_DIVOV;
          end
          if (ex_err == ERR_NONE) begin
            ex_mem_we   = 1'b1;
            ex_mem_addr = SADDR_W'(sp_r - 32'd2);
            ex_mem_data = (op_t'(op_r) == OP_ADD) ? a_r + b_v :
                          (op_t'(op_r) == OP_SUB) ? a_r - b_v :
                          (op_t'(op_r) == OP_MUL) ? prod : dquot;
            ex_sp       = sp_r - 32'd1;
          end
        end
        OP_SET: begin
          ex_err = pop_chk(sp_r, 2'd2);
          if (ex_err == ERR_NONE && !reg_ok(a_r)) ex_err = ERR_BADREG;
          if (ex_err == ERR_NONE) begin
            ex_sp = sp_r - 32'd2;
            if (a_r == 32'd8)      ex_ip = b_v;
            else if (a_r == 32'd9) ex_sp = b_v;
            else begin
              ex_greg_we   = 1'b1;
              ex_greg_idx  = a_r[2:0];
              ex_greg_data = b_v;
            end
          end
        end
        OP_MOV: begin
          if (!reg_ok(i1_r) || !reg_ok(i2_r)) ex_err = ERR_BADREG;
          else if (i2_r == 32'd8) ex_ip = rd1_val;
          else if (i2_r == 32'd9) ex_sp = rd1_val;
          else begin
            ex_greg_we   = 1'b1;
            ex_greg_idx  = i2_r[2:0];
            ex_greg_data = rd1_val;
          end
        end
        OP_IF, OP_IFN: begin
          if (!reg_ok(i1_r)) ex_err = ERR_BADREG;
          else if ((op_t'(op_r) == OP_IF) == (rd1_val == i2_r)) ex_ip = i3_r;
        end
        OP_GLD: begin
          if (!reg_ok(i1_r)) ex_err = ERR_BADREG;
          else ex_err = push_chk(sp_r);
          if (ex_err == ERR_NONE) begin
            ex_mem_we   = 1'b1;
            ex_mem_data = rd1_val;
            ex_sp       = sp_r + 32'd1;
          end
        end
        OP_GPT: begin
          if (!reg_ok(i1_r)) ex_err = ERR_BADREG;
          else ex_err = pop_chk(sp_r, 2'd1);
          if (ex_err == ERR_NONE) begin
            ex_sp = sp_r - 32'd1;
            if (i1_r == 32'd8)      ex_ip = a_r;
            else if (i1_r == 32'd9) ex_sp = a_r;
            else begin
              ex_greg_we   = 1'b1;
              ex_greg_idx  = i1_r[2:0];
              ex_greg_data = a_r;
            end
          end
        end
        OP_LOG: begin
          ex_kind = EMIT_LOG;
          ex_val  = i1_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.is_div     = (op_t'(op_r) == OP_DIV) && !halt_r && (ex_err == ERR_NONE);
    stat.div_done   = (dcnt_r == DCNT_W'(0));
    stat.clear_done = (clr_addr_r == SADDR_W'(STACK_DEPTH - 1));
  end

  // Single write port shared by the clearing pass and execution.
  logic               mem_we;
  logic [SADDR_W-1:0] mem_waddr;
  logic [31:0]        mem_wdata;
  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = commit && ex_mem_we;
      mem_waddr = ex_mem_addr;
      mem_wdata = ex_mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_top || cmd.rd_next) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) gregs_r[k] <= '0;
      ip_r       <= '0;
      sp_r       <= '0;
      halt_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clear) clr_addr_r <= clr_addr_r + SADDR_W'(1);
      if (commit) begin
        ip_r   <= ex_ip;
        sp_r   <= ex_sp;
        halt_r <= ex_halt;
        if (ex_greg_we) gregs_r[ex_greg_idx] <= ex_greg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // dd holds |a| shifting into the remainder and collecting quotient bits.
      dd_r   <= a_r[31] ? (32'd0 - a_r) : a_r;
      dq_r   <= b_v[31] ? (32'd0 - b_v) : b_v;
      dneg_r <= a_r[31] ^ b_v[31];
      drem_r <= '0;
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end
    if (cmd.div_step) begin
      if (!dtrial[32]) drem_r <= dtrial;
      else             drem_r <= {drem_r[31:0], dd_r[31]};
      dd_r   <= {dd_r[30:0], ~dtrial[32]};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (commit) begin
      res_ip_r   <= ex_ip;
      res_kind_r <= ex_kind;
      res_val_r  <= ex_val;
      res_halt_r <= ex_halt;
      res_err_r  <= ex_err;
    end
  end

  assign out_next_ip    = res_ip_r;
  assign out_emit_kind  = res_kind_r;
  assign out_emit_value = res_val_r;
  assign out_halted     = res_halt_r;
  assign out_error_code = res_err_r;

endmodule
`default_nettype wire

FILE: rtl/core/stack_machine_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: stack machine instruction executor
// Top level joining the sequencing controller and the execution datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one instruction and yields exactly one result
// transaction. The result is offered once the instruction has passed through
// the two reads of the stack memory and the execute step. A division that
// passes its checks then steps through the one-bit-per-cycle divider before
// its result is offered. A new instruction is accepted once the previous
// result has been taken, so instructions do not overlap. After reset the
// input stays stalled while a clearing pass zeroes the stack memory.
module stack_machine_execute_unit import sme_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [31:0] in_imm_first,
  input  wire logic [31:0] in_imm_second,
  input  wire logic [31:0] in_imm_third,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_next_ip,
  output logic [1:0]       out_emit_kind,
  output logic [31:0]      out_emit_value,
  output logic             out_halted,
  output logic [2:0]       out_error_code
);

  cmd_t  cmd;
  stat_t stat;

  sme_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  sme_dpath u_dpath (
    .clk, .rst_n, .cmd, .stat, .in_op, .in_imm_first, .in_imm_second,
    .in_imm_third, .out_next_ip, .out_emit_kind, .out_emit_value,
    .out_halted, .out_error_code
  );

endmodule
`default_nettype wire
